FILE: rtl/smeu_pkg.sv
// Package for the stack machine execute unit: payload structs, opcode and
// status codes, stack sizing constants and divider interface types.
// No dependencies.
`default_nettype none

package smeu_pkg;

   localparam int DATA_W      = 32;
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int COUNT_W     = 7;
   localparam int DIV_CNT_W   = $clog2(DATA_W);

   // opcodes
   localparam logic [3:0] OP_ADD    = 4'd0;
   localparam logic [3:0] OP_SUB    = 4'd1;
   localparam logic [3:0] OP_MUL    = 4'd2;
   localparam logic [3:0] OP_DIV    = 4'd3;
   localparam logic [3:0] OP_POP    = 4'd4;
   localparam logic [3:0] OP_PUSH   = 4'd5;
   localparam logic [3:0] OP_DUP    = 4'd6;
   localparam logic [3:0] OP_SWAP   = 4'd7;
   localparam logic [3:0] OP_PRINT  = 4'd8;
   localparam logic [3:0] OP_PRINTC = 4'd9;
   localparam logic [3:0] OP_HALT   = 4'd10;
   localparam logic [3:0] OP_INC    = 4'd11;
   localparam logic [3:0] OP_DEC    = 4'd12;
   localparam logic [3:0] OP_NOP    = 4'd13;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_HALT     = 3'd1;
   localparam logic [2:0] ST_UNDER    = 3'd2;
   localparam logic [2:0] ST_OVER     = 3'd3;
   localparam logic [2:0] ST_DIV0     = 3'd4;
   localparam logic [2:0] ST_NOTASCII = 3'd5;
   localparam logic [2:0] ST_IGNORED  = 3'd6;

   localparam logic [DATA_W-1:0] ASCII_MAX = DATA_W'(127);

   typedef struct packed {
      logic [3:0]               func;
      logic signed [DATA_W-1:0] immediate;
   } req_type;

   typedef struct packed {
      logic [2:0]               status;
      logic                     print_valid;
      logic signed [DATA_W-1:0] print_value;
      logic                     print_as_char;
      logic [COUNT_W-1:0]       stack_count;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

   // low bits of the stack pointer as the reported count
   function automatic logic [COUNT_W-1:0] count_of(input logic [SP_W-1:0] sp);
      logic [SP_W+COUNT_W-1:0] ext;
      ext = {{COUNT_W{1'b0}}, sp};
      return ext[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: sequencer, stack RAM and divider.
// Depends on smeu_pkg, smeu_ram and smeu_div.
`default_nettype none

// One instruction per req transaction, one rsp transaction per instruction, in
// order. The stack lives in a 64 x 32 RAM with registered reads; its top and
// next entries are read continuously at the current stack pointer, so an
// accepted instruction passes from accept into execute, where it writes
// back and loads the result register. SWAP adds a second write state, and
// DIV runs a one-bit-per-cycle divider and waits in S_DIV until it is done.
// The next instruction is taken as soon as the sequencer is back in idle,
// even while the previous result still waits on rsp_stall; apart from the
// divider wait, execution only holds when the result register is still
// occupied. Errors (underflow, overflow, divide by zero, printc out of
// range) leave the stack untouched. After HALT every instruction answers
// "ignored" until reset. Stack entries need no clearing after reset: only
// entries below the stack pointer are ever used.
module stack_machine_execute_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire smeu_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output smeu_pkg::rsp_type      rsp_data
);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_WR2  = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [smeu_pkg::SP_W-1:0]   sp_ff, sp_in;
   logic                        halted_ff, halted_in;
   logic [3:0]                  func_ff;
   logic [smeu_pkg::DATA_W-1:0] imm_ff;
   logic [smeu_pkg::DATA_W-1:0] hold_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   smeu_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // stack addresses around the pointer
   logic [smeu_pkg::SP_W-1:0]   sp_m1, sp_m2, sp_p1;
   logic [smeu_pkg::ADDR_W-1:0] top_addr, nxt_addr, push_addr;
   logic [smeu_pkg::DATA_W-1:0] top, nxt;

   // RAM write port
   logic                        ram_we;
   logic [smeu_pkg::ADDR_W-1:0] ram_waddr;
   logic [smeu_pkg::DATA_W-1:0] ram_wdata;

   // execute decode
   logic [2:0]                  x_status;
   logic                        x_pv, x_pch;
   logic [smeu_pkg::DATA_W-1:0] x_pval;
   logic                        x_we;
   logic [smeu_pkg::ADDR_W-1:0] x_waddr;
   logic [smeu_pkg::DATA_W-1:0] x_wdata;
   logic [smeu_pkg::SP_W-1:0]   x_sp;
   logic                        x_div, x_wr2, x_halt;
   logic                        has1, has2, full;
   logic [smeu_pkg::DATA_W-1:0] product;

   logic                        accept, out_free;
   smeu_pkg::div_req_type       div_req;
   smeu_pkg::div_rsp_type       div_rsp;

   assign sp_m1     = sp_ff - smeu_pkg::SP_W'(1);
   assign sp_m2     = sp_ff - smeu_pkg::SP_W'(2);
   assign sp_p1     = sp_ff + smeu_pkg::SP_W'(1);
   assign top_addr  = sp_m1[smeu_pkg::ADDR_W-1:0];
   assign nxt_addr  = sp_m2[smeu_pkg::ADDR_W-1:0];
   assign push_addr = sp_ff[smeu_pkg::ADDR_W-1:0];

   assign has1 = (sp_ff != '0);
   assign has2 = (sp_ff >= smeu_pkg::SP_W'(2));
   assign full = (sp_ff >= smeu_pkg::SP_W'(smeu_pkg::STACK_DEPTH));

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   smeu_ram #(
      .WIDTH (smeu_pkg::DATA_W),
      .DEPTH (smeu_pkg::STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (top_addr),
      .rd_data_a (top),
      .rd_addr_b (nxt_addr),
      .rd_data_b (nxt)
   );

   assign div_req.start    = (state_ff == S_EXEC) && x_div;
   assign div_req.dividend = nxt;
   assign div_req.divisor  = top;

   smeu_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign product = nxt * top;

   // instruction decode against the operands read this cycle
   always_comb begin
      x_status = smeu_pkg::ST_OK;
      x_pv     = 1'b0;
      x_pch    = 1'b0;
      x_pval   = '0;
      x_we     = 1'b0;
      x_waddr  = nxt_addr;
      x_wdata  = top;
      x_sp     = sp_ff;
      x_div    = 1'b0;
      x_wr2    = 1'b0;
      x_halt   = 1'b0;
      if (halted_ff) begin
         x_status = smeu_pkg::ST_IGNORED;
      end else begin
         unique case (func_ff) inside
            smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL: begin
               if (!has2) begin
                  x_status = smeu_pkg::ST_UNDER;
               end else begin
                  x_we    = 1'b1;
                  x_waddr = nxt_addr;
                  x_sp    = sp_m1;
                  if (func_ff == smeu_pkg::OP_ADD) begin
                     x_wdata = nxt + top;
                  end else if (func_ff == smeu_pkg::OP_SUB) begin
                     x_wdata = nxt - top;
                  end else begin
                     x_wdata = product;
                  end
               end
            end
            smeu_pkg::OP_DIV: begin
               if (!has2) begin
                  x_status = smeu_pkg::ST_UNDER;
               end else if (top == '0) begin
                  x_status = smeu_pkg::ST_DIV0;
               end else begin
                  x_div = 1'b1;
               end
            end
            smeu_pkg::OP_SWAP: begin
               if (!has2) begin
                  x_status = smeu_pkg::ST_UNDER;
               end else begin
                  // top slot now, next slot in the second write state
                  x_we    = 1'b1;
                  x_waddr = top_addr;
                  x_wdata = nxt;
                  x_wr2   = 1'b1;
               end
            end
            smeu_pkg::OP_PUSH, smeu_pkg::OP_DUP: begin
               if (func_ff == smeu_pkg::OP_DUP && !has1) begin
                  x_status = smeu_pkg::ST_UNDER;
               end else if (full) begin
                  x_status = smeu_pkg::ST_OVER;
               end else begin
                  x_we    = 1'b1;
                  x_waddr = push_addr;
                  x_wdata = (func_ff == smeu_pkg::OP_PUSH) ? imm_ff : top;
                  x_sp    = sp_p1;
               end
            end
            smeu_pkg::OP_POP, smeu_pkg::OP_PRINT, smeu_pkg::OP_PRINTC: begin
               if (!has1) begin
                  x_status = smeu_pkg::ST_UNDER;
               end else if (func_ff == smeu_pkg::OP_PRINTC && top > smeu_pkg::ASCII_MAX) begin
                  x_status = smeu_pkg::ST_NOTASCII;
               end else begin
                  x_sp = sp_m1;
                  if (func_ff != smeu_pkg::OP_POP) begin
                     x_pv   = 1'b1;
                     x_pval = top;
                     x_pch  = (func_ff == smeu_pkg::OP_PRINTC);
                  end
               end
            end
            smeu_pkg::OP_INC, smeu_pkg::OP_DEC: begin
               if (!has1) begin
                  x_status = smeu_pkg::ST_UNDER;
               end else begin
                  x_we    = 1'b1;
                  x_waddr = top_addr;
                  x_wdata = (func_ff == smeu_pkg::OP_INC) ? top + 1'b1 : top - 1'b1;
               end
            end
            smeu_pkg::OP_HALT: begin
               x_status = smeu_pkg::ST_HALT;
               x_halt   = 1'b1;
            end
            default: begin
               // nop and undefined opcodes
            end
         endcase
      end
   end

   // sequencer, write port and result register
   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      halted_in    = halted_ff;
      ram_we       = 1'b0;
      ram_waddr    = x_waddr;
      ram_wdata    = x_wdata;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (x_div) begin
               state_in = S_DIV;
            end else if (x_wr2) begin
               ram_we   = 1'b1;
               state_in = S_WR2;
            end else if (out_free) begin
               ram_we                    = x_we;
               sp_in                     = x_sp;
               halted_in                 = halted_ff || x_halt;
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = x_status;
               rsp_data_in.print_valid   = x_pv;
               rsp_data_in.print_value   = x_pval;
               rsp_data_in.print_as_char = x_pch;
               rsp_data_in.stack_count   = smeu_pkg::count_of(x_sp);
               state_in                  = S_IDLE;
            end
         end
         S_WR2: begin
            ram_waddr = nxt_addr;
            ram_wdata = hold_ff;
            if (out_free) begin
               ram_we                    = 1'b1;
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = smeu_pkg::ST_OK;
               rsp_data_in.print_valid   = 1'b0;
               rsp_data_in.print_value   = '0;
               rsp_data_in.print_as_char = 1'b0;
               rsp_data_in.stack_count   = smeu_pkg::count_of(sp_ff);
               state_in                  = S_IDLE;
            end
         end
         S_DIV: begin
            ram_waddr = nxt_addr;
            ram_wdata = div_rsp.quotient;
            if (div_rsp.done && out_free) begin
               ram_we                    = 1'b1;
               sp_in                     = sp_m1;
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = smeu_pkg::ST_OK;
               rsp_data_in.print_valid   = 1'b0;
               rsp_data_in.print_value   = '0;
               rsp_data_in.print_as_char = 1'b0;
               rsp_data_in.stack_count   = smeu_pkg::count_of(sp_m1);
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         func_ff <= req_data.func;
         imm_ff  <= req_data.immediate;
      end
      if (state_ff == S_EXEC) begin
         hold_ff <= top;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= smeu_pkg::SP_W'(smeu_pkg::STACK_DEPTH))
      else $error("stack pointer beyond depth");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag dropped without reset");

   a_div_operands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (has2 && !halted_ff))
      else $error("division running without two operands");

   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && x_div) |=> (state_ff == S_DIV && div_rsp.busy))
      else $error("divider not started on div");

endmodule

`default_nettype wire

FILE: rtl/smeu_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module smeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: rtl/smeu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on smeu_pkg.
`default_nettype none

module smeu_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire smeu_pkg::div_req_type req,
   output smeu_pkg::div_rsp_type     rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [smeu_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [smeu_pkg::DATA_W-1:0]     rem_ff, rem_in;
   logic [smeu_pkg::DATA_W-1:0]     quo_ff, quo_in;
   logic [smeu_pkg::DATA_W-1:0]     den_ff, den_in;
   logic                            neg_ff, neg_in;
   logic [smeu_pkg::DATA_W:0]       trial;
   logic [smeu_pkg::DATA_W:0]       diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[smeu_pkg::DATA_W-1]};
      diff    = trial - {1'b0, den_ff};
      if (req.start) begin
         // magnitudes in, sign applied on the way out
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '1;
         rem_in  = '0;
         quo_in  = req.dividend[smeu_pkg::DATA_W-1] ? (0 - req.dividend) : req.dividend;
         den_in  = req.divisor[smeu_pkg::DATA_W-1] ? (0 - req.divisor) : req.divisor;
         neg_in  = req.dividend[smeu_pkg::DATA_W-1] ^ req.divisor[smeu_pkg::DATA_W-1];
      end else if (busy_ff) begin
         if (!diff[smeu_pkg::DATA_W]) begin
            rem_in = diff[smeu_pkg::DATA_W-1:0];
         end else begin
            rem_in = trial[smeu_pkg::DATA_W-1:0];
         end
         quo_in = {quo_ff[smeu_pkg::DATA_W-2:0], ~diff[smeu_pkg::DATA_W]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? (0 - quo_ff) : quo_ff;

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done together");

endmodule

`default_nettype wire
